>>> hdl/hbpwm_pkg.sv
package hbpwm_pkg;

	localparam int PeriodW = 15;
	localparam int DeadW   = 8;
	localparam int PowerW  = 16;
	localparam int IndexW  = 2;

	localparam logic [PeriodW-1:0] PERIOD_TOP_RST = PeriodW'(5000);
	localparam logic [DeadW-1:0]   DEAD_TICKS_RST = DeadW'(5);
	localparam logic               POLARITY_RST   = 1'b0;

	// Operation codes of a request
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// Configuration register indexes
	typedef enum logic [IndexW-1:0] {
		REG_PERIOD_TOP = 2'd0,
		REG_DEAD_TICKS = 2'd1,
		REG_POLARITY   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                     op;
		logic signed [PowerW-1:0] power;
	} req_t;

	typedef struct packed {
		logic [PeriodW-1:0] period_top;
		logic [DeadW-1:0]   dead_ticks;
		logic               polarity_invert;
	} cfg_t;

	typedef struct packed {
		logic high_left;
		logic high_right;
		logic low_left;
		logic low_right;
	} gate_t;

	typedef struct packed {
		gate_t gate;
		logic  period_wrap;
	} res_t;

endpackage

>>> hdl/hbpwm_cmd_if.sv
interface hbpwm_cmd_if
	import hbpwm_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic signed [PowerW-1:0] power;

	modport source (output valid, output op, output power, input ready);
	modport sink (input valid, input op, input power, output ready);
endinterface

>>> hdl/hbpwm_res_if.sv
interface hbpwm_res_if;
	logic valid;
	logic ready;
	logic high_left;
	logic high_right;
	logic low_left;
	logic low_right;
	logic period_wrap;

	modport source (output valid, output high_left, output high_right, output low_left,
		output low_right, output period_wrap, input ready);
	modport sink (input valid, input high_left, input high_right, input low_left,
		input low_right, input period_wrap, output ready);
endinterface

>>> hdl/hbpwm_cfg_if.sv
interface hbpwm_cfg_if
	import hbpwm_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [IndexW-1:0]  index;
	logic [PeriodW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/hbpwm_sat.sv
// Clip the power request to +/- period_top, then apply polarity.
module hbpwm_sat
	import hbpwm_pkg::*;
(
	input  logic signed [PowerW-1:0] power,
	input  logic [PeriodW-1:0]       period_top,
	input  logic                     polarity_invert,
	output logic signed [PowerW-1:0] sat_power
);

	logic signed [PowerW-1:0] lim;
	logic signed [PowerW-1:0] neg_lim;
	logic signed [PowerW-1:0] clip;

	assign lim     = signed'({1'b0, period_top});
	assign neg_lim = -lim;

	always_comb begin
		clip = power;
		if (power > lim) begin
			clip = lim;
		end else if (power < neg_lim) begin
			clip = neg_lim;
		end
	end

	assign sat_power = polarity_invert ? -clip : clip;

endmodule

>>> hdl/hbpwm_core.sv
// Period counter, dead-time counter and gate state; one request per enable.
module hbpwm_core
	import hbpwm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  req_t                     req,
	input  logic signed [PowerW-1:0] sat_power,
	input  cfg_t                     cfg,
	output res_t                     res_next
);

	logic [PeriodW-1:0]       count_q, count_n;
	logic signed [PowerW-1:0] cmd_q, cmd_n;
	logic signed [PowerW-1:0] act_q, act_n;
	logic [DeadW-1:0]         dead_q, dead_n;
	logic                     seen_q, seen_n;
	gate_t                    gate_q, gate_n;

	logic                     wrap;
	logic                     drive;
	logic [PowerW-1:0]        abs_act;
	logic [PeriodW-1:0]       mag;

	assign wrap = (count_q >= cfg.period_top);

	always_comb begin
		count_n = count_q;
		cmd_n   = cmd_q;
		act_n   = act_q;
		dead_n  = dead_q;
		seen_n  = seen_q;
		gate_n  = gate_q;
		drive   = 1'b0;
		abs_act = '0;
		mag     = '0;
		if (req.op == OP_SET) begin
			cmd_n = sat_power;
		end else begin
			if (wrap) begin
				// new period: all off, latch the command, restart dead time
				count_n = '0;
				gate_n  = '0;
				act_n   = cmd_q;
				seen_n  = 1'b0;
				dead_n  = cfg.dead_ticks;
			end else begin
				count_n = count_q + PeriodW'(1);
			end
			abs_act = act_n[PowerW-1] ? PowerW'(-act_n) : PowerW'(act_n);
			mag     = abs_act[PeriodW-1:0];
			if (act_n != '0 && mag < cfg.period_top && count_n == mag) begin
				seen_n = 1'b1;
				gate_n = '0;
			end
			if (wrap) begin
				drive = (dead_n == '0);
			end else if (dead_q != '0) begin
				dead_n = dead_q - DeadW'(1);
				drive  = (dead_n == '0);
			end
			if (drive && act_n != '0 && !seen_n) begin
				gate_n = '0;
				if (act_n[PowerW-1]) begin
					gate_n.low_right = 1'b1;
					gate_n.high_left = 1'b1;
				end else begin
					gate_n.low_left   = 1'b1;
					gate_n.high_right = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cmd_q   <= '0;
			act_q   <= '0;
			dead_q  <= '0;
			seen_q  <= 1'b0;
			gate_q  <= '0;
		end else if (step) begin
			count_q <= count_n;
			cmd_q   <= cmd_n;
			act_q   <= act_n;
			dead_q  <= dead_n;
			seen_q  <= seen_n;
			gate_q  <= gate_n;
		end
	end

	assign res_next.gate        = gate_n;
	assign res_next.period_wrap = (req.op == OP_TICK) && wrap;

endmodule

>>> hdl/hbridge_sign_magnitude_pwm_unit.sv
// H-bridge sign-magnitude PWM with dead time. Each request on cmd is either a
// timer tick (op = 0) or a new power command (op = 1); every request yields
// exactly one result on res carrying the four gate drives after the request
// and a flag that marks the tick which wrapped the period counter. The unit
// takes one request per clock: a request lands in an input register, one
// short pass of logic (clip, counter compare, dead-time count) updates the
// bridge state, and the result lands in an output register; a request can
// enter in every cycle while res is taken.
// A stalled result holds the pipe; cmd.ready follows res.ready in the same
// cycle. The three registers (period_top, dead_ticks, polarity_invert) are
// written through cfg, which is always ready; write them only when no
// request is in flight. Polarity and the limit apply when a command is set,
// the command becomes active at the next period wrap.
module hbridge_sign_magnitude_pwm_unit
	import hbpwm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	hbpwm_cmd_if.sink    cmd,
	hbpwm_res_if.source  res,
	hbpwm_cfg_if.sink    cfg
);

	cfg_t                     cfg_q;
	req_t                     req_s1;
	logic                     valid_s1;
	res_t                     res_q;
	logic                     res_valid_q;
	logic                     advance;
	logic signed [PowerW-1:0] sat_power;
	res_t                     res_next;

	// Register writes; an index past the list is dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_top      <= PERIOD_TOP_RST;
			cfg_q.dead_ticks      <= DEAD_TICKS_RST;
			cfg_q.polarity_invert <= POLARITY_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_PERIOD_TOP: cfg_q.period_top      <= cfg.data;
				REG_DEAD_TICKS: cfg_q.dead_ticks      <= cfg.data[DeadW-1:0];
				REG_POLARITY:   cfg_q.polarity_invert <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Advance the input stage when the result register is free or drains now
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			req_s1.op    <= cmd.op;
			req_s1.power <= cmd.power;
		end
	end

	hbpwm_sat u_sat (
		.power           (req_s1.power),
		.period_top      (cfg_q.period_top),
		.polarity_invert (cfg_q.polarity_invert),
		.sat_power       (sat_power)
	);

	hbpwm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.req       (req_s1),
		.sat_power (sat_power),
		.cfg       (cfg_q),
		.res_next  (res_next)
	);

	// Result register: load on advance, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.high_left   = res_q.gate.high_left;
	assign res.high_right  = res_q.gate.high_right;
	assign res.low_left    = res_q.gate.low_left;
	assign res.low_right   = res_q.gate.low_right;
	assign res.period_wrap = res_q.period_wrap;

endmodule

>>> hdl/hbpwm_checker.sv
module hbpwm_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic high_left,
	input logic high_right,
	input logic low_left,
	input logic low_right,
	input logic period_wrap,
	input logic cfg_valid,
	input logic cfg_ready
);

	// No shoot-through on either leg
	a_no_shoot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(high_left && low_left) && !(high_right && low_right))
		else $error("shoot-through on a bridge leg");

	// Gates are all off or exactly one diagonal
	a_diagonal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ($countones({high_left, high_right, low_left, low_right}) == 0)
			|| (low_left && high_right && !low_right && !high_left)
			|| (low_right && high_left && !low_left && !high_right))
		else $error("gates not a valid diagonal");

	// A stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
			&& $stable({high_left, high_right, low_left, low_right, period_wrap}))
		else $error("stalled result changed");

	// Register writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind hbridge_sign_magnitude_pwm_unit hbpwm_checker u_hbpwm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.high_left   (res.high_left),
	.high_right  (res.high_right),
	.low_left    (res.low_left),
	.low_right   (res.low_right),
	.period_wrap (res.period_wrap),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);
